>>> sv/ese_pkg.sv
// Shared types and constants for the exchange sort engine.
// Depends on nothing; every other file of the block imports it.
package ese_pkg;

    // Number of cells in the insertion chain, from 2 up to 64.
    localparam int CAPACITY = 64;

    typedef struct packed {
        logic signed [31:0] value;
        logic               final_item;
    } item_word_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               end_of_run;
        logic               overflowed;
    } result_word_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic               load;
        logic               drain;
        logic signed [31:0] new_value;
    } cell_ctrl_t;

    // What one cell shows to its neighbours.
    typedef struct packed {
        logic signed [31:0] value;
        logic               valid;
        logic               wants;
    } cell_link_t;

endpackage

>>> sv/ese_cell.sv
// One cell of the insertion chain: a held value, its valid bit and the place test.
// Depends on ese_pkg for the control and neighbour link structs.
module ese_cell
    import ese_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_link_t left,
    input  cell_link_t right,
    output cell_link_t link
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               valid_reg;
    logic               valid_next;
    logic               wants;

    // The new value belongs here or further left when this cell is empty or holds
    // a strictly greater value, so equal values keep their arrival order.
    assign wants = !valid_reg || (value_reg > ctrl.new_value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.drain)
        begin
            value_next = right.value;
            valid_next = right.valid;
        end
        else if (ctrl.load && wants)
        begin
            if (left.wants)
            begin
                value_next = left.value;
                valid_next = left.valid;
            end
            else
            begin
                value_next = ctrl.new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value = value_reg;
    assign link.valid = valid_reg;
    assign link.wants = wants;

endmodule

>>> sv/exchange_sort_engine_core.sv
// Exchange sort engine: a row of insertion cells that keeps a set in ascending order.
// Depends on ese_pkg and ese_cell.
// Loading takes one word per cycle; each word is placed by the cell chain in that cycle.
// The first result appears the cycle after the final word is accepted, then one result
// per cycle while not stalled; no new word is taken during that drain. Reset clears
// every valid bit at once, so no clearing pass is needed.
module exchange_sort_engine_core
    import ese_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  item_word_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_word_t result
);

    localparam logic [CAPACITY-1:0] VEC_ONE = {{(CAPACITY - 1){1'b0}}, 1'b1};

    cell_link_t          links [CAPACITY];
    cell_ctrl_t          ctrl;
    logic [CAPACITY-1:0] valid_vec;
    logic                full;
    logic                item_take;
    logic                result_take;
    logic                last_head;
    logic                draining_reg;
    logic                draining_next;
    logic                drop_reg;
    logic                drop_next;

    // The valid cells always form an unbroken run from cell zero, so the chain is
    // full exactly when its last cell holds a value.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
            valid_vec[i] = links[i].valid;
    end

    assign full        = valid_vec[CAPACITY-1];
    assign item_stall  = draining_reg;
    assign item_take   = item_valid && !item_stall;
    assign result_take = result_valid && !result_stall;

    // While loading, every cell sees the new word and decides locally whether to keep,
    // shift right or capture it. While draining, the row shifts towards cell zero.
    assign ctrl.load      = item_take && !full;
    assign ctrl.drain     = result_take;
    assign ctrl.new_value = item.value;

    localparam cell_link_t EMPTY_LINK = '{value: '0, valid: 1'b0, wants: 1'b0};

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        cell_link_t left_link;
        cell_link_t right_link;

        if (g == 0)
        begin : g_first
            assign left_link = EMPTY_LINK;
        end
        else
        begin : g_inner_left
            assign left_link = links[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_link = EMPTY_LINK;
        end
        else
        begin : g_inner_right
            assign right_link = links[g+1];
        end

        ese_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left_link),
            .right (right_link),
            .link  (links[g])
        );
    end

    // Cell zero is the head of the sorted set; it is the last one when cell one is empty.
    assign last_head = !valid_vec[1];

    assign result_valid        = draining_reg && valid_vec[0];
    assign result.sorted_value = links[0].value;
    assign result.end_of_run   = last_head;
    assign result.overflowed   = drop_reg;

    always_comb
    begin
        draining_next = draining_reg;
        drop_next     = drop_reg;
        if (result_take && last_head)
        begin
            draining_next = 1'b0;
            drop_next     = 1'b0;
        end
        else if (item_take)
        begin
            if (full)
                drop_next = 1'b1;
            if (item.final_item)
                draining_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            drop_reg     <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
            drop_reg     <= drop_next;
        end
    end

    // The held values always occupy a contiguous run starting at cell zero.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + VEC_ONE)) == '0)
        else $error("valid cells do not form a prefix of the chain");

    // A drain never starts or continues on an empty chain.
    a_drain_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> valid_vec[0])
        else $error("drain running with an empty chain");

    // Results leave in ascending order.
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (result_take && !last_head) |=>
            (result_valid && (result.sorted_value >= $past(result.sorted_value))))
        else $error("results not in ascending order");

    // A word taken while the chain is full leaves the valid bits of the chain unchanged.
    a_drop_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && full) |=> $stable(valid_vec))
        else $error("dropped word altered the chain");

    // After the final result the engine is empty and ready for the next set.
    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_take && last_head) |=> (valid_vec == '0 && !draining_reg && !drop_reg))
        else $error("engine not cleared after end of run");

endmodule

>>> tb/sort_order_checker.sv
// Checker for the exchange sort engine: watches both channels, predicts each sorted run
// and compares every result word with it. Depends on ese_pkg.
`timescale 1ns / 100ps

module sort_order_checker
    import ese_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         item_stall,
    input  item_word_t   item,
    input  logic         result_valid,
    input  logic         result_stall,
    input  result_word_t result,
    output int           mismatches,
    output int           results_due,
    output int           results_seen,
    output int           sets_seen,
    output int           overflow_sets
);

    // Values of the set being loaded, kept in ascending order; equal values in arrival order.
    logic signed [31:0] held_set[$];
    logic               set_dropped;
    result_word_t       sorted_due[$];

    function automatic void place_word(input item_word_t w);
        int slot;
        if (held_set.size() < CAPACITY)
        begin
            slot = held_set.size();
            // The first held value strictly greater than the new one marks its place.
            for (int i = held_set.size() - 1; i >= 0; i--)
                if (held_set[i] > w.value)
                    slot = i;
            held_set.insert(slot, w.value);
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (w.final_item)
        begin
            for (int k = 0; k < held_set.size(); k++)
                sorted_due.push_back({held_set[k], k == held_set.size() - 1, set_dropped});
            sets_seen++;
            if (set_dropped)
                overflow_sets++;
            held_set.delete();
            set_dropped = 1'b0;
        end
    endfunction

    function automatic void check_word(input result_word_t got);
        result_word_t want;
        results_seen++;
        if (sorted_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result word: value %0d end %0b overflow %0b",
                         $time, got.sorted_value, got.end_of_run, got.overflowed);
        end
        else
        begin
            want = sorted_due.pop_front();
            if (got.sorted_value !== want.sorted_value || got.end_of_run !== want.end_of_run
                    || got.overflowed !== want.overflowed)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             $time, want.sorted_value, want.end_of_run, want.overflowed,
                             got.sorted_value, got.end_of_run, got.overflowed);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_set.delete();
            sorted_due.delete();
            set_dropped   = 1'b0;
            mismatches    = 0;
            results_due   = 0;
            results_seen  = 0;
            sets_seen     = 0;
            overflow_sets = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                place_word(item);
            if (result_valid && !result_stall)
                check_word(result);
            results_due = sorted_due.size();
        end
    end

endmodule

>>> tb/exchange_sort_engine_core_tb.sv
// Top of the exchange sort engine testbench: clock, reset, word stimulus and verdict.
// Depends on ese_pkg, exchange_sort_engine_core and sort_order_checker.
`timescale 1ns / 100ps

module exchange_sort_engine_core_tb;
    import ese_pkg::*;

    // The cycle limit is far above the slowest correct run: roughly 460 words with random
    // gaps, every result waiting out a stall burst, plus the long hold-off.
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_stall;
    item_word_t   item;
    logic         result_valid;
    logic         result_stall;
    result_word_t result;

    int mismatches;
    int results_due;
    int results_seen;
    int sets_seen;
    int overflow_sets;

    int cycle_count;
    int words_sent;
    bit idling_on  = 1'b0;
    bit hold_armed = 1'b0;

    exchange_sort_engine_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    sort_order_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .mismatches    (mismatches),
        .results_due   (results_due),
        .results_seen  (results_seen),
        .sets_seen     (sets_seen),
        .overflow_sets (overflow_sets)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one word and returns at the clock edge on which it is taken. When idling is
    // on, the word is sometimes preceded by a burst of empty cycles. The valid is only
    // lowered when a gap really follows, so it never drops and rises in the same step.
    task automatic send_word(input logic signed [31:0] v, input logic last);
        item_word_t next_word;
        int         gap;
        next_word.value      = v;
        next_word.final_item = last;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= next_word;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        words_sent++;
    endtask

    // Values lean towards the ends of the range and towards a narrow band around zero,
    // the latter so that equal values turn up often within one set.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000 + $urandom_range(0, 3);
            1:       return 32'sh7fff_ffff - $urandom_range(0, 3);
            2, 3:    return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int k = 0; k < n; k++)
            send_word(pick_value(), k == n - 1);
    endtask

    // The sender holds back until the checker has seen every result it predicted.
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
    endtask

    // Result side: random stall bursts while idling is on, and one long hold-off on
    // request, counted here so that the sender keeps offering words while the engine is
    // stuck in its drain.
    initial
    begin
        int stall_left;
        result_stall = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_armed)
            begin
                hold_armed = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                stall_left = $urandom_range(0, 5);
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a run that hangs is a failed run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
        $display("** exchange_sort_engine_core: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        words_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets. A set of one word, the most negative value.
        send_word(32'sh8000_0000, 1'b1);
        // Both extremes, zero, and a repeated value that arrives last.
        send_word(32'sh7fff_ffff, 1'b0);
        send_word(32'shffff_ffff, 1'b0);
        send_word(32'sh0000_0000, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'shffff_ffff, 1'b1);
        // Every value equal: all of them must come back.
        repeat (3) send_word(32'sh1234_5678, 1'b0);
        send_word(32'sh1234_5678, 1'b1);
        // Already in ascending order.
        send_word(-32'sd3, 1'b0);
        send_word(-32'sd2, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd0, 1'b1);
        // Strictly descending, with alternating bit patterns.
        send_word(32'sh5555_5555, 1'b0);
        send_word(32'sh0000_0001, 1'b0);
        send_word(32'shffff_fffe, 1'b0);
        send_word(32'shaaaa_aaaa, 1'b1);
        wait_drained();

        // Random sets, mostly short, with idling on both sides.
        idling_on = 1'b1;
        while (words_sent < 110)
            send_set($urandom_range(1, 12));

        // A set that fills the store exactly. The receiver then holds off for a long
        // while, so the next set backs up against the stalled input.
        send_set(CAPACITY);
        hold_armed = 1'b1;
        while (words_sent < 200)
            send_set($urandom_range(1, 12));

        // A set that overruns the store: the trailing words, the final one among them,
        // are dropped and the whole run must carry the overflow flag.
        send_set(CAPACITY + 1 + $urandom_range(0, 4));
        wait_drained();

        while (words_sent < 400)
            send_set($urandom_range(1, 12));

        // Last stretch at full rate on both sides.
        idling_on = 1'b0;
        while (words_sent < 460)
            send_set($urandom_range(1, 12));

        // Let the last drain finish, then watch a while longer for stray result words.
        wait_drained();
        repeat (2 * CAPACITY + 8) @(posedge clk);

        $display("Sorted %0d sets from %0d words; %0d result words checked.",
                 sets_seen, words_sent, results_seen);
        $display("%0d sets overran the store; %0d mismatches.", overflow_sets, mismatches);
        if (mismatches == 0 && results_due == 0)
            $display("** exchange_sort_engine_core: PASSED **");
        else
            $display("** exchange_sort_engine_core: FAILED **");
        $finish;
    end

endmodule
